@@ rtl/core/nwls_pkg.sv @@
// Shared types, constants and score arithmetic for the last-row scoring core.
// No dependencies; imported by the column cells, the head column and the top level.
`default_nettype none

package nwls_pkg;

   localparam int SCORE_WIDTH = 24;
   localparam int MAX_REF_DEF = 1024;
   localparam int COL_W       = 17;   // holds any column number up to the largest MAX_REF
   localparam int IDX_W       = 11;
   localparam int SYM_W       = 8;
   localparam int STEP_W      = 6;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int PROD_W      = 32;

   localparam logic [1:0] OP_RESTART = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_FEED    = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MISMATCH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAP      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH   = 2'd3;

   typedef logic signed [SCORE_WIDTH-1:0] score_type;
   typedef logic signed [STEP_W-1:0]      step_type;

   localparam score_type SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
   localparam score_type SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

   // scoring setup captured with each item, so a wavefront keeps the setup it entered with
   typedef struct packed {
      logic [3:0]       match;
      logic signed [4:0] mismatch;
      logic signed [4:0] gap;
      logic [IDX_W-1:0] len;      // length already limited to the number of cells
   } cfg_type;

   // one item travelling down the column chain
   typedef struct packed {
      logic             vld;
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic [SYM_W-1:0] sym;
      logic             flag;     // read column lies beyond the length
      cfg_type          cfg;
      score_type        left;     // new score of the left column, or the read score
      score_type        diag;     // old score of the left column
   } tok_type;

   function automatic step_type ext_step5(input logic signed [4:0] v);
      ext_step5 = $signed({v[4], v});
   endfunction

   function automatic score_type add_sat(input score_type a, input step_type b);
      logic signed [SCORE_WIDTH:0] sum;
      sum = (SCORE_WIDTH+1)'(a) + (SCORE_WIDTH+1)'(b);
      if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) begin
         add_sat = sum[SCORE_WIDTH] ? SCORE_MIN : SCORE_MAX;
      end else begin
         add_sat = sum[SCORE_WIDTH-1:0];
      end
   endfunction

   // column number times gap, saturated
   function automatic score_type restart_val(input logic [COL_W-1:0] col,
                                             input logic signed [4:0] gap);
      logic signed [PROD_W-1:0] prod;
      prod = $signed({{(PROD_W-COL_W){1'b0}}, col}) * $signed({{(PROD_W-5){gap[4]}}, gap});
      if (prod > PROD_W'(SCORE_MAX)) begin
         restart_val = SCORE_MAX;
      end else if (prod < PROD_W'(SCORE_MIN)) begin
         restart_val = SCORE_MIN;
      end else begin
         restart_val = prod[SCORE_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/nwls_head.sv @@
// Column zero of the scoring chain: holds the boundary score and launches items.
// Depends on nwls_pkg.
`default_nettype none

module nwls_head (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire nwls_pkg::tok_type link_in,
   output nwls_pkg::tok_type     link_out
);
   import nwls_pkg::*;

   score_type score_ff, score_in;
   tok_type   tok_ff, tok_in;
   score_type bound_nx;

   always_comb begin
      bound_nx = add_sat(score_ff, ext_step5(link_in.cfg.gap));
      tok_in       = link_in;
      tok_in.flag  = 1'b0;
      tok_in.left  = '0;
      tok_in.diag  = '0;
      score_in     = score_ff;
      case (link_in.op)
         OP_RESTART: begin
            if (link_in.vld) score_in = '0;
         end
         OP_FEED: begin
            if (link_in.vld) score_in = bound_nx;
            tok_in.left = bound_nx;
            tok_in.diag = score_ff;
         end
         OP_READ: begin
            tok_in.flag = (link_in.idx > link_in.cfg.len);
            if (link_in.idx == '0) tok_in.left = score_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff   <= '0;
         tok_ff.vld <= 1'b0;
      end else if (advance) begin
         score_ff <= score_in;
         tok_ff   <= tok_in;
      end
   end

   assign link_out = tok_ff;

endmodule

`default_nettype wire

@@ rtl/core/nwls_cell.sv @@
// One reference column of the scoring chain: reference symbol and row score.
// Depends on nwls_pkg.
`default_nettype none

module nwls_cell #(
   parameter int COL = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire nwls_pkg::tok_type link_in,
   output nwls_pkg::tok_type     link_out
);
   import nwls_pkg::*;

   localparam logic [COL_W-1:0] COL_ID   = COL_W'(COL);
   localparam logic [COL_W-1:0] COL_PREV = COL_W'(COL - 1);
   localparam score_type        SCORE_RST = restart_val(COL_ID, 5'sd0 - 5'sd1);

   score_type        score_ff, score_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   tok_type          tok_ff, tok_in;
   logic             col_on;
   logic [COL_W-1:0] idx_ext;
   step_type         step, gap6;
   score_type        diag_sum, up_sum, left_sum, best;

   always_comb begin
      col_on   = (COL_ID <= COL_W'(link_in.cfg.len));
      idx_ext  = COL_W'(link_in.idx);
      gap6     = ext_step5(link_in.cfg.gap);
      step     = (sym_ff == link_in.sym) ? $signed({2'b00, link_in.cfg.match})
                                         : ext_step5(link_in.cfg.mismatch);
      diag_sum = add_sat(link_in.diag, step);
      up_sum   = add_sat(score_ff, gap6);
      left_sum = add_sat(link_in.left, gap6);
      best     = diag_sum;
      if (up_sum > best) best = up_sum;
      if (left_sum > best) best = left_sum;

      tok_in   = link_in;
      score_in = score_ff;
      sym_in   = sym_ff;
      case (link_in.op)
         OP_RESTART: begin
            if (link_in.vld) score_in = restart_val(COL_ID, link_in.cfg.gap);
         end
         OP_WRITE: begin
            if (link_in.vld && idx_ext == COL_PREV) sym_in = link_in.sym;
         end
         OP_FEED: begin
            if (col_on) begin
               if (link_in.vld) score_in = best;
               tok_in.left = best;
               tok_in.diag = score_ff;
            end
         end
         OP_READ: begin
            if (idx_ext == COL_ID && !link_in.flag) tok_in.left = score_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff   <= SCORE_RST;
         tok_ff.vld <= 1'b0;
      end else if (advance) begin
         score_ff <= score_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) sym_ff <= sym_in;
   end

   assign link_out = tok_ff;

endmodule

`default_nettype wire

@@ rtl/core/nw_last_row_score.sv @@
// Top level of the last-row global alignment scoring core.
// Depends on nwls_pkg, nwls_head and nwls_cell.
//
// The core keeps one alignment row as a chain of MAX_REF column cells behind a
// head column that holds the boundary score. Every transfer on the req_ side
// (restart, reference write, query feed, score read) enters the head and moves
// one cell per cycle down the chain while the chain advances. A query symbol
// therefore sweeps the row as a wavefront, and the next item follows behind
// it. One item is taken per cycle while the chain advances. A read passes the
// head register and then every cell register, and rsp_tvalid rises when the
// response register loads as the read leaves the chain. The read picks up its
// score as it passes its column. Only reads produce a response. The chain holds
// still (and req_tready drops) while the response register is full and a read
// has reached the end of the chain. This holds even when the waiting response
// transfers in that same cycle, so each read of a back-to-back run waits until
// the previous response has left. Each item carries the scoring registers that
// were in force when it was taken, so register writes take effect for later
// items only.
// The reference store lives in the cells and has no reset: feeding a query
// against a position that was never written gives unspecified scores. The row
// and boundary scores reset to the restart pattern (column times -1, zero).
`default_nettype none

module nw_last_row_score #(
   parameter int MAX_REF = nwls_pkg::MAX_REF_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [23:0]                     req_tdata,  // index[10:0], symbol[18:11]
   input  wire logic [1:0]                      req_tuser,  // operation[1:0]
   // response channel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [23:0]                          rsp_tdata,  // score[23:0]
   output logic [0:0]                           rsp_tuser,  // status[0]
   // register write port
   input  wire logic                            csr_wen,
   input  wire logic [nwls_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [nwls_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nwls_pkg::*;

   // scoring registers
   logic [3:0]        match_ff;
   logic signed [4:0] mismatch_ff;
   logic signed [4:0] gap_ff;
   logic [IDX_W-1:0]  length_ff;
   logic [IDX_W-1:0]  len_used;

   // chain links: entry 0 leaves the head, entry c leaves column c
   tok_type link [0:MAX_REF];
   tok_type entry;
   tok_type tail;

   logic      advance;
   logic      rsp_valid_ff;
   score_type rsp_score_ff;
   logic      rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 4'd1;
         mismatch_ff <= -5'sd1;
         gap_ff      <= -5'sd1;
         length_ff   <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_MATCH:    match_ff    <= csr_wdata[3:0];
            CSR_MISMATCH: mismatch_ff <= $signed(csr_wdata[4:0]);
            CSR_GAP:      gap_ff      <= $signed(csr_wdata[4:0]);
            CSR_LENGTH:   length_ff   <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // limit the row width to the number of cells
   assign len_used = (COL_W'(length_ff) > COL_W'(MAX_REF)) ? IDX_W'(MAX_REF) : length_ff;

   // build the item that enters the head
   always_comb begin
      entry              = '0;
      entry.vld          = req_tvalid;
      entry.op           = req_tuser;
      entry.idx          = req_tdata[IDX_W-1:0];
      entry.sym          = req_tdata[IDX_W+SYM_W-1:IDX_W];
      entry.cfg.match    = match_ff;
      entry.cfg.mismatch = mismatch_ff;
      entry.cfg.gap      = gap_ff;
      entry.cfg.len      = len_used;
   end

   // hold the whole chain while a read waits at the end behind a full response
   assign tail       = link[MAX_REF];
   assign advance    = !(rsp_valid_ff && tail.vld && tail.op == OP_READ);
   assign req_tready = advance;

   nwls_head u_head (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .link_in  (entry),
      .link_out (link[0])
   );

   for (genvar c = 1; c <= MAX_REF; c++) begin : g_col
      nwls_cell #(
         .COL (c)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .link_in  (link[c-1]),
         .link_out (link[c])
      );
   end

   // response register: drop on transfer, load when a read leaves the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && tail.vld && tail.op == OP_READ) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tail.vld && tail.op == OP_READ) begin
         rsp_score_ff  <= tail.flag ? '0 : tail.left;
         rsp_status_ff <= tail.flag;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_score_ff;
   assign rsp_tuser[0] = rsp_status_ff;

endmodule

`default_nettype wire

@@ tb/tb_nw_last_row_score.sv @@
// Self-checking testbench for nw_last_row_score: directed and random request streams
// checked against a score predictor held in a small scoreboard class.
// Depends on nwls_pkg and the nw_last_row_score RTL.
`default_nettype none

module tb_nw_last_row_score;
   import nwls_pkg::*;

   localparam int MAX_REF = MAX_REF_DEF;
   // a read passes the head and every cell before it answers; leave some margin on top
   localparam int DRAIN_CYCLES = MAX_REF + 8;
   // longest quiet stretch of a correct run is one drain plus a burst of idling
   localparam int STALL_LIMIT = 16 * (MAX_REF + 16);

   typedef struct packed {
      logic signed [SCORE_WIDTH-1:0] score;
      logic                          status;
   } read_result_type;

   // Predicts the last-row scores and keeps the read results still to come.
   class last_row_predictor;
      byte unsigned    ref_sym [MAX_REF];
      longint          row [MAX_REF+1];
      longint          boundary;
      longint          match_pts;
      longint          mismatch_pts;
      longint          gap_pts;
      int unsigned     ref_len;
      read_result_type expected_reads [$];
      int              mismatch_count;

      function new();
         match_pts      = 1;
         mismatch_pts   = -1;
         gap_pts        = -1;
         ref_len        = 0;
         mismatch_count = 0;
         foreach (ref_sym[i]) ref_sym[i] = 8'd0;
         restart_row();
      endfunction

      function longint clip(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) << (SCORE_WIDTH - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function int unsigned used_len();
         return (ref_len > MAX_REF) ? MAX_REF : ref_len;
      endfunction

      function void restart_row();
         for (int j = 0; j <= MAX_REF; j++) row[j] = clip(longint'(j) * gap_pts);
         boundary = 0;
      endfunction

      // one query symbol sweeps columns 1..L
      function void feed_row(byte unsigned q);
         int unsigned len;
         longint diag;
         longint up_old;
         longint best;
         longint up;
         longint left;
         len      = used_len();
         diag     = row[0];
         boundary = clip(boundary + gap_pts);
         row[0]   = boundary;
         for (int j = 1; j <= len; j++) begin
            up_old = row[j];
            best   = clip(diag + ((ref_sym[j-1] == q) ? match_pts : mismatch_pts));
            up     = clip(up_old + gap_pts);
            left   = clip(row[j-1] + gap_pts);
            if (up > best) best = up;
            if (left > best) best = left;
            row[j] = best;
            diag   = up_old;
         end
      endfunction

      function void set_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_MATCH:    match_pts    = longint'(data[3:0]);
            CSR_MISMATCH: mismatch_pts = longint'($signed(data[4:0]));
            CSR_GAP:      gap_pts      = longint'($signed(data[4:0]));
            CSR_LENGTH:   ref_len      = 32'(data[10:0]);
            default: ;
         endcase
      endfunction

      function void take_request(logic [1:0] op, int unsigned idx, byte unsigned sym);
         read_result_type res;
         case (op)
            OP_RESTART: restart_row();
            OP_WRITE:   if (idx < MAX_REF) ref_sym[idx] = sym;
            OP_FEED:    feed_row(sym);
            OP_READ: begin
               if (idx <= used_len()) begin
                  res.score  = row[idx][SCORE_WIDTH-1:0];
                  res.status = 1'b0;
               end else begin
                  res.score  = '0;
                  res.status = 1'b1;
               end
               expected_reads.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_read_result(logic signed [SCORE_WIDTH-1:0] score, logic status);
         read_result_type want;
         if (expected_reads.size() == 0) begin
            $error("unexpected response: score %0d status %0d", score, status);
            mismatch_count++;
            return;
         end
         want = expected_reads.pop_front();
         if (score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, score);
            mismatch_count++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_reads.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;   // index[10:0], symbol[18:11]
   logic [1:0]             req_tuser  = '0;   // operation[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;         // score[23:0]
   logic [0:0]             rsp_tuser;         // status[0]
   logic                   csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   last_row_predictor book;
   bit                sym_loaded [MAX_REF];   // reference positions written so far
   bit                req_idle_on = 1'b0;
   bit                rsp_idle_on = 1'b0;
   int                rsp_hold    = 0;
   int                quiet_cycles = 0;

   nw_last_row_score #(.MAX_REF(MAX_REF)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sample both channels at the edge with the values that were there before it.
   // Feed every request transfer to the predictor, check every response transfer,
   // and count the cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            book.take_request(req_tuser, 32'(req_tdata[10:0]), req_tdata[18:11]);
         if (rsp_tvalid && rsp_tready)
            book.check_read_result($signed(rsp_tdata), rsp_tuser[0]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Back-pressure on the response side: rsp_tready drops in random bursts.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold   <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Mostly a tiny alphabet so matches are common; now and then any byte.
   function automatic int unsigned pick_symbol();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
   endfunction

   // Present one request and hold it until the transfer happens.
   task automatic send(input logic [1:0] op, input int unsigned idx, input int unsigned sym);
      int unsigned gap_len;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap_len    = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         req_tdata  <= 24'($urandom);
         req_tuser  <= 2'($urandom);
         repeat (gap_len) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, sym[7:0], idx[10:0]};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, wait for every read to answer, then let the chain empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      book.set_register(addr, data);
      @(posedge clock);
   endtask

   // Load all four registers; unused upper data bits carry noise.
   task automatic set_regs(input int m, input int mm, input int g, input int unsigned len);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom); v[3:0] = m[3:0];
      write_reg(CSR_MATCH, v);
      v = CSR_DATA_W'($urandom); v[4:0] = mm[4:0];
      write_reg(CSR_MISMATCH, v);
      v = CSR_DATA_W'($urandom); v[4:0] = g[4:0];
      write_reg(CSR_GAP, v);
      write_reg(CSR_LENGTH, len[10:0]);
      csr_wen <= 1'b0;
   endtask

   // One setting: restart, load any reference positions still missing, then a
   // random mix weighted toward feeds and reads of the active row.
   task automatic run_phase(input int m, input int mm, input int g, input int unsigned len,
                            input int n_items, input bit idle_ok);
      int unsigned ulen;
      int unsigned r;
      int unsigned idx;
      settle();
      set_regs(m, mm, g, len);
      ulen = (len > MAX_REF) ? MAX_REF : len;
      send(OP_RESTART, $urandom_range(0, 2047), $urandom_range(0, 255));
      for (int p = 0; p < ulen; p++) begin
         if (!sym_loaded[p]) begin
            send(OP_WRITE, p, pick_symbol());
            sym_loaded[p] = 1'b1;
         end
      end
      for (int k = 0; k < n_items; k++) begin
         // switch idling on and off in stretches
         if (k % 10 == 0) begin
            req_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
            rsp_idle_on = idle_ok && ($urandom_range(0, 3) != 0);
         end
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send(OP_FEED, $urandom_range(0, 2047), pick_symbol());
         end else if (r < 72) begin
            send(OP_READ, $urandom_range(0, ulen), $urandom_range(0, 255));
         end else if (r < 80) begin
            send(OP_READ, $urandom_range(0, 2047), $urandom_range(0, 255));
         end else if (r < 92) begin
            idx = (ulen > 0 && r < 88) ? $urandom_range(0, ulen - 1) : $urandom_range(0, 2047);
            send(OP_WRITE, idx, pick_symbol());
            if (idx < MAX_REF) sym_loaded[idx] = 1'b1;
         end else begin
            send(OP_RESTART, $urandom_range(0, 2047), $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      book = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset setup, length zero: reads at and past the row, a feed that only moves the
      // boundary, writes past the store that must be dropped, writes into it, a restart
      send(OP_READ, 0, 'h00);
      send(OP_READ, 1, 'hFF);
      send(OP_READ, 2047, 'h00);
      send(OP_FEED, 0, 'hFF);
      send(OP_READ, 0, 'h00);
      send(OP_WRITE, 1024, 'hAA);
      send(OP_WRITE, 2047, 'h5A);
      send(OP_WRITE, 0, 'h00);
      send(OP_WRITE, 1, 'hFF);
      send(OP_WRITE, 2, 'h55);
      sym_loaded[0] = 1'b1;
      sym_loaded[1] = 1'b1;
      sym_loaded[2] = 1'b1;
      send(OP_RESTART, 0, 'h00);
      send(OP_READ, 0, 'h00);

      // short row: matches and mismatches, every column, one past the end
      settle();
      set_regs(2, -3, -2, 3);
      send(OP_RESTART, 0, 'h00);
      send(OP_FEED, 0, 'h00);
      send(OP_FEED, 0, 'hFF);
      send(OP_FEED, 0, 'h55);
      send(OP_FEED, 2047, 'h12);
      for (int c = 0; c <= 4; c++) send(OP_READ, c, 'h00);
      send(OP_RESTART, 0, 'h00);
      send(OP_READ, 3, 'h00);

      // random part: register extremes, a length past the store, the full store,
      // an empty row, then random settings; the last one runs without idling
      run_phase(0, -15, -15, 1, 20, 1'b1);
      run_phase(15, 15, 0, 17, 20, 1'b1);
      run_phase(15, -15, -15, 2047, 20, 1'b1);
      run_phase(7, 0, -7, 1024, 20, 1'b1);
      run_phase($urandom_range(0, 15), int'($urandom_range(0, 30)) - 15,
                -int'($urandom_range(0, 15)), 0, 20, 1'b1);
      run_phase($urandom_range(0, 15), int'($urandom_range(0, 30)) - 15,
                -int'($urandom_range(0, 15)), $urandom_range(1, 64), 20, 1'b1);
      run_phase($urandom_range(0, 15), int'($urandom_range(0, 30)) - 15,
                -int'($urandom_range(0, 15)), $urandom_range(1, 64), 20, 1'b1);
      run_phase($urandom_range(0, 15), int'($urandom_range(0, 30)) - 15,
                -int'($urandom_range(0, 15)), $urandom_range(1, 64), 20, 1'b0);

      // drain, then give stray responses a chance to show up
      settle();
      if (book.mismatch_count == 0 && book.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/nwls_pkg.sv
rtl/core/nwls_head.sv
rtl/core/nwls_cell.sv
rtl/core/nw_last_row_score.sv
tb/tb_nw_last_row_score.sv
